@@ rtl/cssu_pkg.sv @@
// ----------------------------------------------------------------------------
// cssu_pkg
// Types, codes and constants shared by the converter start-up sequencer.
// ----------------------------------------------------------------------------
package cssu_pkg;

    localparam int TIME_BITS  = 32;
    localparam int NOW_BITS   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [2:0] {
        ST_CAL    = 3'd0,
        ST_IDLE   = 3'd1,
        ST_WAIT   = 3'd2,
        ST_CLOSE  = 3'd3,
        ST_INRUSH = 3'd4,
        ST_RUN    = 3'd5,
        ST_FAULT  = 3'd6
    } seq_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_PRESENT_LEVEL = 3'd0,
        CFG_FREQ_LOW_LIMIT     = 3'd1,
        CFG_FREQ_HIGH_LIMIT    = 3'd2,
        CFG_GRID_MIN_RMS       = 3'd3,
        CFG_BUS_OVERVOLT_LIMIT = 3'd4,
        CFG_INRUSH_DELAY_MS    = 3'd5
    } cfg_index_t;

    localparam logic [14:0] GRID_PRESENT_LEVEL_RST = 15'd3277;
    localparam logic [14:0] FREQ_LOW_LIMIT_RST     = 15'd11520;
    localparam logic [14:0] FREQ_HIGH_LIMIT_RST    = 15'd16640;
    localparam logic [13:0] GRID_MIN_RMS_RST       = 14'd900;
    localparam logic [13:0] BUS_OVERVOLT_LIMIT_RST = 14'd8000;
    localparam logic [15:0] INRUSH_DELAY_MS_RST    = 16'd100;

    typedef struct packed {
        logic [14:0] grid_present_level;
        logic [14:0] freq_low_limit;
        logic [14:0] freq_high_limit;
        logic [13:0] grid_min_rms;
        logic [13:0] bus_overvolt_limit;
        logic [15:0] inrush_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic                calibration_done;
        logic signed [15:0]  grid_d_level;
        logic [14:0]         pll_freq;
        logic [13:0]         rms_phase_a;
        logic [13:0]         rms_phase_b;
        logic [13:0]         rms_phase_c;
        logic [13:0]         bus_volts;
        logic                overcurrent_seen;
        logic [NOW_BITS-1:0] now_ms;
    } meas_item_t;

    typedef struct packed {
        logic [2:0] seq_state;
        logic       phase_relay_on;
        logic       inrush_relay_on;
        logic       overcurrent_armed;
        logic       power_stage_go;
        logic       gate_pwm_off;
        logic       relays_connected;
        logic       fault_general;
        logic       fault_grid_undervolt;
        logic       fault_bus_overvolt;
    } status_item_t;

    typedef struct packed {
        seq_state_t st;
        time_t      start_time;
        logic       connect_mark;
        logic       phase_relay;
        logic       inrush_relay;
        logic       oc_armed;
        logic       power_go;
        logic       pwm_off;
        logic       flt_general;
        logic       flt_undervolt;
        logic       flt_overvolt;
    } seq_ctx_t;

endpackage

@@ rtl/cssu_if.sv @@
// ----------------------------------------------------------------------------
// cssu_if
// Valid/ready channels for measurement words and status words.
// ----------------------------------------------------------------------------
interface cssu_meas_if;
    import cssu_pkg::*;

    logic       valid;
    logic       ready;
    meas_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cssu_status_if;
    import cssu_pkg::*;

    logic         valid;
    logic         ready;
    status_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cssu_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cssu_cfg_regs
// Limit and delay registers written through the plain write port.
// ----------------------------------------------------------------------------
module cssu_cfg_regs
    import cssu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_GRID_PRESENT_LEVEL: cfg_next.grid_present_level = cfg_wdata[14:0];
                CFG_FREQ_LOW_LIMIT:     cfg_next.freq_low_limit     = cfg_wdata[14:0];
                CFG_FREQ_HIGH_LIMIT:    cfg_next.freq_high_limit    = cfg_wdata[14:0];
                CFG_GRID_MIN_RMS:       cfg_next.grid_min_rms       = cfg_wdata[13:0];
                CFG_BUS_OVERVOLT_LIMIT: cfg_next.bus_overvolt_limit = cfg_wdata[13:0];
                CFG_INRUSH_DELAY_MS:    cfg_next.inrush_delay_ms    = cfg_wdata[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_present_level <= GRID_PRESENT_LEVEL_RST;
            cfg_reg.freq_low_limit     <= FREQ_LOW_LIMIT_RST;
            cfg_reg.freq_high_limit    <= FREQ_HIGH_LIMIT_RST;
            cfg_reg.grid_min_rms       <= GRID_MIN_RMS_RST;
            cfg_reg.bus_overvolt_limit <= BUS_OVERVOLT_LIMIT_RST;
            cfg_reg.inrush_delay_ms    <= INRUSH_DELAY_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/cssu_step.sv @@
// ----------------------------------------------------------------------------
// cssu_step
// Next-state logic of the sequence for one measurement word.
// ----------------------------------------------------------------------------
module cssu_step
    import cssu_pkg::*;
(
    input  cfg_t       cfg,
    input  seq_ctx_t   ctx,
    input  meas_item_t meas,
    output seq_ctx_t   ctx_next
);

    time_t              now_t;
    time_t              elapsed;
    logic [TIME_BITS:0] elapsed_x;
    logic [TIME_BITS:0] delay_x;
    logic [TIME_BITS:0] delay2_x;
    logic               grid_seen;
    logic               freq_bad;
    logic               undervolt;
    logic               overvolt;

    always_comb
    begin
        now_t     = TIME_BITS'(meas.now_ms);
        elapsed   = now_t - ctx.start_time;
        elapsed_x = (TIME_BITS + 1)'(elapsed);
        delay_x   = (TIME_BITS + 1)'(cfg.inrush_delay_ms);
        delay2_x  = (TIME_BITS + 1)'({cfg.inrush_delay_ms, 1'b0});
        grid_seen = meas.grid_d_level > $signed({1'b0, cfg.grid_present_level});
        freq_bad  = (meas.pll_freq > cfg.freq_high_limit) ||
                    (meas.pll_freq < cfg.freq_low_limit);
        undervolt = (meas.rms_phase_a < cfg.grid_min_rms) ||
                    (meas.rms_phase_b < cfg.grid_min_rms) ||
                    (meas.rms_phase_c < cfg.grid_min_rms);
        overvolt  = meas.bus_volts > cfg.bus_overvolt_limit;

        ctx_next = ctx;
        case (ctx.st)
            ST_CAL:
            begin
                if (meas.calibration_done)
                begin
                    ctx_next.st = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ctx_next.st = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (grid_seen)
                begin
                    if (freq_bad)
                    begin
                        ctx_next.flt_general = 1'b1;
                        ctx_next.st          = ST_FAULT;
                    end
                    else
                    begin
                        ctx_next.st = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE:
            begin
                ctx_next.oc_armed     = 1'b0;
                ctx_next.phase_relay  = 1'b1;
                ctx_next.connect_mark = 1'b1;
                ctx_next.start_time   = now_t;
                ctx_next.st           = ST_INRUSH;
            end
            ST_INRUSH:
            begin
                if (ctx.connect_mark && (elapsed_x > delay_x))
                begin
                    ctx_next.inrush_relay = 1'b1;
                    if (elapsed_x > delay2_x)
                    begin
                        ctx_next.oc_armed = 1'b1;
                        if (meas.overcurrent_seen)
                        begin
                            ctx_next.st = ST_FAULT;
                        end
                        else
                        begin
                            ctx_next.power_go = 1'b1;
                            ctx_next.st       = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (undervolt)
                begin
                    ctx_next.flt_undervolt = 1'b1;
                end
                if (overvolt)
                begin
                    ctx_next.flt_overvolt = 1'b1;
                end
                if (freq_bad)
                begin
                    ctx_next.flt_general = 1'b1;
                end
                if (undervolt || overvolt || freq_bad)
                begin
                    ctx_next.st = ST_FAULT;
                end
            end
            default:
            begin
                ctx_next.st           = ST_FAULT;
                ctx_next.connect_mark = 1'b0;
                ctx_next.pwm_off      = 1'b1;
                ctx_next.phase_relay  = 1'b0;
                ctx_next.inrush_relay = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/converter_startup_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// converter_startup_sequencer_unit
// An accepted measurement word passes the input register and then the status register.
// Throughput: 1 word per cycle while the status channel is not stalled, set by the
// combinational next-state step between the input register and the status register.
// Reset: sequence in calibrate, overcurrent armed, relays open, faults clear,
// limits at their default values; no words held.
// ----------------------------------------------------------------------------
module converter_startup_sequencer_unit
    import cssu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    cssu_meas_if.sink             meas,
    cssu_status_if.source         status
);

    cfg_t         cfg;
    seq_ctx_t     ctx_reg;
    seq_ctx_t     ctx_next;
    logic         in_valid_reg;
    logic         in_valid_next;
    meas_item_t   in_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    status_item_t out_data_reg;
    status_item_t out_data_next;
    logic         advance;
    logic         meas_take;

    cssu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cssu_step u_step (
        .cfg      (cfg),
        .ctx      (ctx_reg),
        .meas     (in_data_reg),
        .ctx_next (ctx_next)
    );

    always_comb
    begin
        advance   = in_valid_reg && (!out_valid_reg || status.ready);
        meas_take = meas.valid && meas.ready;

        in_valid_next = in_valid_reg;
        if (meas_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end

        out_data_next.seq_state            = ctx_next.st;
        out_data_next.phase_relay_on       = ctx_next.phase_relay;
        out_data_next.inrush_relay_on      = ctx_next.inrush_relay;
        out_data_next.overcurrent_armed    = ctx_next.oc_armed;
        out_data_next.power_stage_go       = ctx_next.power_go;
        out_data_next.gate_pwm_off         = ctx_next.pwm_off;
        out_data_next.relays_connected     = ctx_next.connect_mark;
        out_data_next.fault_general        = ctx_next.flt_general;
        out_data_next.fault_grid_undervolt = ctx_next.flt_undervolt;
        out_data_next.fault_bus_overvolt   = ctx_next.flt_overvolt;
    end

    assign meas.ready   = !in_valid_reg || advance;
    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctx_reg.st            <= ST_CAL;
            ctx_reg.start_time    <= '0;
            ctx_reg.connect_mark  <= 1'b0;
            ctx_reg.phase_relay   <= 1'b0;
            ctx_reg.inrush_relay  <= 1'b0;
            ctx_reg.oc_armed      <= 1'b1;
            ctx_reg.power_go      <= 1'b0;
            ctx_reg.pwm_off       <= 1'b0;
            ctx_reg.flt_general   <= 1'b0;
            ctx_reg.flt_undervolt <= 1'b0;
            ctx_reg.flt_overvolt  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_take)
        begin
            in_data_reg <= meas.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for converter_startup_sequencer_unit. Measurement words drive the
// sequencer along its single start-up path. The path starts with a short
// table of opening ticks and moves on to random ticks in wait, inrush and
// run. It ends in the sticky fault state, entered from wait, inrush or run
// as the seed picks. A local sequencer model predicts each status word not
// typed in the table; each is compared field by field as it leaves the block.
// Limits are rewritten between phases once all status words are checked.
// ----------------------------------------------------------------------------
module tb
    import cssu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int TICK_TARGET = 1300;
    localparam int HOLD_AT     = 300;
    localparam int LONG_HOLD   = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef enum int {TRIP_IN_WAIT, TRIP_IN_INRUSH, TRIP_IN_RUN} trip_path_t;

    typedef struct {
        meas_item_t   word;
        bit           typed;
        status_item_t want;
    } tick_row_t;

    localparam status_item_t CAL_WORD =
        '{ST_CAL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam status_item_t IDLE_WORD =
        '{ST_IDLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam status_item_t WAIT_WORD =
        '{ST_WAIT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cssu_meas_if   meas_ch ();
    cssu_status_if status_ch ();

    converter_startup_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .meas      (meas_ch),
        .status    (status_ch)
    );

    seq_ctx_t     seq_model;
    cfg_t         limits_model;
    status_item_t status_due[$];
    status_item_t status_want;

    int  n_sent;
    int  n_checked;
    int  n_mismatch;
    int  n_writes;
    int  send_gap_pct = 7;
    int  recv_gap_pct = 52;
    int  hold_left;
    int  stall_cycles;
    bit  hold_req;

    tick_row_t opening_ticks [9] = '{
        '{'{1'b0, 16'sh0000, 15'd0, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, 32'h0},
          1'b1, CAL_WORD},
        '{'{1'b0, 16'sh7FFF, 15'd25599, 14'd10000, 14'd10000, 14'd10000, 14'd10000,
            1'b1, 32'hFFFF_FFFF}, 1'b1, CAL_WORD},
        '{'{1'b0, 16'sh8000, 15'd16384, 14'd8192, 14'd5461, 14'd2730, 14'd8191,
            1'b0, 32'h8000_0000}, 1'b1, CAL_WORD},
        '{'{1'b1, 16'sh8000, 15'd0, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, 32'h1},
          1'b1, IDLE_WORD},
        '{'{1'b0, 16'sh7FFF, 15'd0, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, 32'h2},
          1'b1, WAIT_WORD},
        '{'{1'b1, 16'sh8000, 15'd0, 14'd900, 14'd900, 14'd900, 14'd8000, 1'b1, 32'h3},
          1'b1, WAIT_WORD},
        '{'{1'b0, 16'sd3277, 15'd0, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, 32'h4},
          1'b1, WAIT_WORD},
        '{'{1'b0, 16'sd3277, 15'd25599, 14'd10000, 14'd0, 14'd10000, 14'd10000,
            1'b0, 32'h5}, 1'b1, WAIT_WORD},
        '{'{1'b1, 16'sd3276, 15'd16640, 14'd899, 14'd901, 14'd10000, 14'd8001,
            1'b1, 32'h6}, 1'b0, '0}
    };

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic logic [15:0] d_at_most(int level);
        return 16'(int'(pick(0, level + 32768)) - 32768);
    endfunction

    function automatic meas_item_t random_tick();
        meas_item_t t;
        t.calibration_done = 1'($urandom_range(1));
        t.grid_d_level     = 16'(pick(0, 65535)) ^ 16'h8000;
        t.pll_freq         = 15'(pick(0, 25599));
        t.rms_phase_a      = 14'(pick(0, 10000));
        t.rms_phase_b      = 14'(pick(0, 10000));
        t.rms_phase_c      = 14'(pick(0, 10000));
        t.bus_volts        = 14'(pick(0, 10000));
        t.overcurrent_seen = 1'($urandom_range(1));
        t.now_ms           = pick(0, 32'hFFFF_FFFF);
        return t;
    endfunction

    // random tick that keeps the run state healthy under the current limits
    function automatic meas_item_t run_tick();
        meas_item_t  t;
        int unsigned bus_top;
        int unsigned freq_top;
        t = random_tick();
        bus_top  = (limits_model.bus_overvolt_limit > 10000) ? 10000 :
                   limits_model.bus_overvolt_limit;
        freq_top = (limits_model.freq_high_limit > 25599) ? 25599 :
                   limits_model.freq_high_limit;
        t.rms_phase_a = 14'(pick(limits_model.grid_min_rms, 10000));
        t.rms_phase_b = 14'(pick(limits_model.grid_min_rms, 10000));
        t.rms_phase_c = 14'(pick(limits_model.grid_min_rms, 10000));
        t.bus_volts   = 14'(pick(0, bus_top));
        t.pll_freq    = 15'(pick(limits_model.freq_low_limit, freq_top));
        return t;
    endfunction

    function automatic bit freq_outside(logic [14:0] f);
        return f > limits_model.freq_high_limit || f < limits_model.freq_low_limit;
    endfunction

    function automatic status_item_t advance_sequencer(meas_item_t m);
        status_item_t s;
        time_t        elapsed;
        int           grid_d;
        grid_d = $signed(m.grid_d_level);
        case (seq_model.st)
            ST_CAL: begin
                if (m.calibration_done)
                    seq_model.st = ST_IDLE;
            end
            ST_IDLE: seq_model.st = ST_WAIT;
            ST_WAIT: begin
                if (grid_d > int'(limits_model.grid_present_level))
                begin
                    if (freq_outside(m.pll_freq))
                    begin
                        seq_model.flt_general = 1'b1;
                        seq_model.st = ST_FAULT;
                    end
                    else
                    begin
                        seq_model.st = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                seq_model.oc_armed     = 1'b0;
                seq_model.phase_relay  = 1'b1;
                seq_model.connect_mark = 1'b1;
                seq_model.start_time   = m.now_ms;
                seq_model.st           = ST_INRUSH;
            end
            ST_INRUSH: begin
                if (seq_model.connect_mark)
                begin
                    elapsed = m.now_ms - seq_model.start_time;
                    if (elapsed > 32'(limits_model.inrush_delay_ms))
                    begin
                        seq_model.inrush_relay = 1'b1;
                        if (elapsed > 32'(limits_model.inrush_delay_ms) * 2)
                        begin
                            seq_model.oc_armed = 1'b1;
                            if (m.overcurrent_seen)
                            begin
                                seq_model.st = ST_FAULT;
                            end
                            else
                            begin
                                seq_model.power_go = 1'b1;
                                seq_model.st = ST_RUN;
                            end
                        end
                    end
                end
            end
            ST_RUN: begin
                if (m.rms_phase_a < limits_model.grid_min_rms ||
                    m.rms_phase_b < limits_model.grid_min_rms ||
                    m.rms_phase_c < limits_model.grid_min_rms)
                begin
                    seq_model.flt_undervolt = 1'b1;
                    seq_model.st = ST_FAULT;
                end
                if (m.bus_volts > limits_model.bus_overvolt_limit)
                begin
                    seq_model.flt_overvolt = 1'b1;
                    seq_model.st = ST_FAULT;
                end
                if (freq_outside(m.pll_freq))
                begin
                    seq_model.flt_general = 1'b1;
                    seq_model.st = ST_FAULT;
                end
            end
            default: begin
                seq_model.st           = ST_FAULT;
                seq_model.connect_mark = 1'b0;
                seq_model.pwm_off      = 1'b1;
                seq_model.phase_relay  = 1'b0;
                seq_model.inrush_relay = 1'b0;
            end
        endcase
        s.seq_state            = seq_model.st;
        s.phase_relay_on       = seq_model.phase_relay;
        s.inrush_relay_on      = seq_model.inrush_relay;
        s.overcurrent_armed    = seq_model.oc_armed;
        s.power_stage_go       = seq_model.power_go;
        s.gate_pwm_off         = seq_model.pwm_off;
        s.relays_connected     = seq_model.connect_mark;
        s.fault_general        = seq_model.flt_general;
        s.fault_grid_undervolt = seq_model.flt_undervolt;
        s.fault_bus_overvolt   = seq_model.flt_overvolt;
        return s;
    endfunction

    task automatic send_tick(input meas_item_t word, input bit typed = 1'b0,
                             input status_item_t want = '0);
        status_item_t predicted;
        @(negedge clk);
        case (n_sent * 3 / TICK_TARGET)
            0: begin send_gap_pct = 7;  recv_gap_pct = 52; end
            1: begin send_gap_pct = 52; recv_gap_pct = 7;  end
            default: begin send_gap_pct = 0; recv_gap_pct = 0; end
        endcase
        while ($urandom_range(99) < send_gap_pct)
        begin
            meas_ch.valid <= 1'b0;
            @(negedge clk);
        end
        meas_ch.valid <= 1'b1;
        meas_ch.data  <= word;
        do @(posedge clk); while (!meas_ch.ready);
        predicted = advance_sequencer(word);
        status_due.push_back(typed ? want : predicted);
        n_sent++;
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        meas_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input cfg_index_t idx, input logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_GRID_PRESENT_LEVEL: limits_model.grid_present_level = value[14:0];
            CFG_FREQ_LOW_LIMIT:     limits_model.freq_low_limit     = value[14:0];
            CFG_FREQ_HIGH_LIMIT:    limits_model.freq_high_limit    = value[14:0];
            CFG_GRID_MIN_RMS:       limits_model.grid_min_rms       = value[13:0];
            CFG_BUS_OVERVOLT_LIMIT: limits_model.bus_overvolt_limit = value[13:0];
            CFG_INRUSH_DELAY_MS:    limits_model.inrush_delay_ms    = value[15:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_limits(input logic [15:0] value);
        cfg_index_t idx;
        idx = idx.first();
        do
        begin
            write_limit(idx, value);
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    task automatic note_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want)
        begin
            n_mismatch++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // status sink: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            status_ch.ready <= 1'b0;
        end
        else
        begin
            status_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                n_mismatch++;
                $display("%0t: status word with none expected, got %p", $time,
                         status_ch.data);
            end
            else
            begin
                status_want = status_due.pop_front();
                note_field("seq_state", status_want.seq_state, status_ch.data.seq_state);
                note_field("phase_relay_on", status_want.phase_relay_on,
                           status_ch.data.phase_relay_on);
                note_field("inrush_relay_on", status_want.inrush_relay_on,
                           status_ch.data.inrush_relay_on);
                note_field("overcurrent_armed", status_want.overcurrent_armed,
                           status_ch.data.overcurrent_armed);
                note_field("power_stage_go", status_want.power_stage_go,
                           status_ch.data.power_stage_go);
                note_field("gate_pwm_off", status_want.gate_pwm_off,
                           status_ch.data.gate_pwm_off);
                note_field("relays_connected", status_want.relays_connected,
                           status_ch.data.relays_connected);
                note_field("fault_general", status_want.fault_general,
                           status_ch.data.fault_general);
                note_field("fault_grid_undervolt", status_want.fault_grid_undervolt,
                           status_ch.data.fault_grid_undervolt);
                note_field("fault_bus_overvolt", status_want.fault_bus_overvolt,
                           status_ch.data.fault_bus_overvolt);
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((meas_ch.valid && meas_ch.ready) || (status_ch.valid && status_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time,
                     stall_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        trip_path_t  trip;
        meas_item_t  t;
        int          level;
        int          lo;
        int          hi;
        int          delay;
        int          fault_mask;
        int          fault_ticks;
        int unsigned start;
        int unsigned offsets[$];

        rst_n           = 1'b0;
        meas_ch.valid   = 1'b0;
        meas_ch.data    = '0;
        status_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_GRID_PRESENT_LEVEL;
        cfg_wdata       = '0;

        seq_model          = '0;
        seq_model.st       = ST_CAL;
        seq_model.oc_armed = 1'b1;
        limits_model = '{GRID_PRESENT_LEVEL_RST, FREQ_LOW_LIMIT_RST, FREQ_HIGH_LIMIT_RST,
                         GRID_MIN_RMS_RST, BUS_OVERVOLT_LIMIT_RST, INRUSH_DELAY_MS_RST};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening_ticks[i])
            send_tick(opening_ticks[i].word, opening_ticks[i].typed, opening_ticks[i].want);

        // hold in wait for grid
        write_limit(CFG_GRID_PRESENT_LEVEL, 16'hFFFF);
        repeat (80) send_tick(random_tick());
        write_limit(CFG_GRID_PRESENT_LEVEL, 16'h0000);
        write_limit(CFG_FREQ_LOW_LIMIT, 16'd25599);
        write_limit(CFG_FREQ_HIGH_LIMIT, 16'd0);
        repeat (60)
        begin
            t = random_tick();
            t.grid_d_level = d_at_most(0);
            send_tick(t);
        end
        level = $urandom_range(32766, 1);
        write_limit(CFG_GRID_PRESENT_LEVEL, 16'(level));
        repeat (60)
        begin
            t = random_tick();
            t.grid_d_level = d_at_most(level);
            send_tick(t);
        end

        case ($urandom_range(7))
            0: trip = TRIP_IN_WAIT;
            1: trip = TRIP_IN_INRUSH;
            default: trip = TRIP_IN_RUN;
        endcase
        level = $urandom_range(1) ? 3277 : $urandom_range(30000);
        lo    = $urandom_range(12800, 1);
        hi    = $urandom_range(25598, lo);
        case ($urandom_range(5))
            0: delay = 0;
            1: delay = 65535;
            default: delay = $urandom_range(300, 1);
        endcase
        write_limit(CFG_GRID_PRESENT_LEVEL, 16'(level));
        write_limit(CFG_FREQ_LOW_LIMIT, 16'(lo));
        write_limit(CFG_FREQ_HIGH_LIMIT, 16'(hi));
        write_limit(CFG_INRUSH_DELAY_MS, 16'(delay));

        // grid shows up
        t = random_tick();
        t.grid_d_level = 16'(pick(level + 1, 32767));
        if (trip == TRIP_IN_WAIT)
            t.pll_freq = 15'($urandom_range(1) ? $urandom_range(lo - 1, 0) :
                             $urandom_range(25599, hi + 1));
        else
            t.pll_freq = 15'(pick(lo, hi));
        send_tick(t);

        if (trip != TRIP_IN_WAIT)
        begin
            t = random_tick();
            if ($urandom_range(1))
                t.now_ms = 32'hFFFF_FFFF - $urandom_range(2 * delay + 20);
            start = t.now_ms;
            send_tick(t);
            offsets = '{0, delay, 2 * delay};
            if (delay > 0)
                offsets.push_back(delay + 1);
            repeat (6) offsets.push_back($urandom_range(2 * delay));
            foreach (offsets[i])
            begin
                t = random_tick();
                t.now_ms = start + offsets[i];
                send_tick(t);
            end
            t = random_tick();
            t.now_ms = ($urandom_range(3) == 0) ? start - 1 :
                       start + 2 * delay + 1 + $urandom_range(50);
            t.overcurrent_seen = (trip == TRIP_IN_INRUSH);
            send_tick(t);
        end

        if (trip == TRIP_IN_RUN)
        begin
            for (int k = 0; k < 7; k++)
            begin
                case (k)
                    0: begin level = 0; delay = 16'hFFFF; lo = 0; hi = 16'hFFFF; end
                    1: begin
                        level = 10000;
                        delay = 0;
                        lo    = $urandom_range(25599);
                        hi    = lo;
                    end
                    6: begin
                        level = $urandom_range(9000, 1);
                        delay = $urandom_range(9999, 100);
                        lo    = $urandom_range(12800, 1);
                        hi    = $urandom_range(25598, lo);
                    end
                    default: begin
                        level = $urandom_range(10000);
                        delay = $urandom_range(10000);
                        lo    = $urandom_range(25599);
                        hi    = $urandom_range(25599, lo);
                    end
                endcase
                // level and delay carry the rms floor and bus ceiling here
                write_limit(CFG_GRID_MIN_RMS, 16'(level));
                write_limit(CFG_BUS_OVERVOLT_LIMIT, 16'(delay));
                write_limit(CFG_FREQ_LOW_LIMIT, 16'(lo));
                write_limit(CFG_FREQ_HIGH_LIMIT, 16'(hi));
                repeat ((k == 6) ? 40 : 130) send_tick(run_tick());
            end

            t = run_tick();
            fault_mask = $urandom_range(7, 1);
            if (fault_mask[0])
            begin
                case ($urandom_range(2))
                    0: t.rms_phase_a =
                        14'($urandom_range(limits_model.grid_min_rms - 1, 0));
                    1: t.rms_phase_b =
                        14'($urandom_range(limits_model.grid_min_rms - 1, 0));
                    default: t.rms_phase_c =
                        14'($urandom_range(limits_model.grid_min_rms - 1, 0));
                endcase
            end
            if (fault_mask[1])
                t.bus_volts =
                    14'($urandom_range(10000, limits_model.bus_overvolt_limit + 1));
            if (fault_mask[2])
            begin
                if ($urandom_range(1))
                    write_limit(CFG_FREQ_LOW_LIMIT, 16'(limits_model.freq_high_limit + 1));
                else
                    t.pll_freq = 15'($urandom_range(1) ?
                                     $urandom_range(limits_model.freq_low_limit - 1, 0) :
                                     $urandom_range(25599, limits_model.freq_high_limit + 1));
            end
            send_tick(t);
        end

        // sticky fault
        write_all_limits(16'h0000);
        fault_ticks = (TICK_TARGET > n_sent + 100) ? TICK_TARGET - n_sent : 100;
        for (int i = 0; i < fault_ticks; i++)
        begin
            if (i == fault_ticks / 2)
                write_all_limits(16'hFFFF);
            send_tick(random_tick());
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d measurement words from calibrate to fault, fault via %s,",
                 n_sent, trip.name());
        $display("with %0d limit writes; %0d status words checked, %0d mismatches.",
                 n_writes, n_checked, n_mismatch);
        if (n_mismatch == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
